// File: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holding at a clock edge implies consequent at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expression must never hold at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// File: hw/rtl/efr_pkg.sv
// shared types, constants and arithmetic helpers of the face flux pipeline
`default_nettype none

package efr_pkg;

    // quotient bits of one velocity division and how they are cut into stages
    localparam int DIV_BITS           = 48;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = DIV_BITS / DIV_BITS_PER_STAGE;
    localparam int FLUX_STAGES        = 9;
    // entry register, divider stages, velocity register, flux stages
    localparam int LATENCY            = DIV_STAGES + 2 + FLUX_STAGES;

    localparam logic [17:0]        GAMMA_RESET = 18'd91750;
    localparam logic signed [18:0] Q_ONE_G     = 19'sd65536;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] SAT_HI  = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO  = -64'sd2147483648;

    localparam logic [DIV_BITS-1:0] Q_POS_LIMIT = 48'h0000_7FFF_FFFF;
    localparam logic [DIV_BITS-1:0] Q_NEG_LIMIT = 48'h0000_8000_0000;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [31:0] total_energy;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic               normal_negate;
        logic [30:0]        normal_mag;
        logic signed [31:0] rotation_term;
    } t_cell;

    // fields that ride along the divider
    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] en;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] rot;
        logic [30:0]        nmag;
        logic               neg;
        logic               bad;
    } t_side;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] w;
    } t_vel;

    typedef struct packed {
        logic [30:0]         rem;
        logic [DIV_BITS-1:0] dq;
    } t_div_lane;

    typedef struct packed {
        logic signed [31:0] mass;
        logic signed [31:0] xmom;
        logic signed [31:0] ymom;
        logic signed [31:0] zmom;
        logic signed [31:0] energy;
        logic               bad;
    } t_flux;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = S32_MAX;
        end else if (v < SAT_LO) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // restoring division, DIV_BITS_PER_STAGE quotient bits per call; dividend shifts out as quotient shifts in
    function automatic t_div_lane div_steps(input t_div_lane x, input logic [30:0] d);
        t_div_lane   y;
        logic [31:0] t;
        y = x;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            t = {y.rem, y.dq[DIV_BITS-1]};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                y.dq = {y.dq[DIV_BITS-2:0], 1'b1};
            end else begin
                y.dq = {y.dq[DIV_BITS-2:0], 1'b0};
            end
            y.rem = t[30:0];
        end
        return y;
    endfunction

    // apply sign to an unsigned quotient and clamp to 32 bits
    function automatic logic signed [31:0] quo_sat(input logic [DIV_BITS-1:0] q,
                                                   input logic neg);
        logic signed [31:0] r;
        if (!neg) begin
            r = (q > Q_POS_LIMIT) ? S32_MAX : q[31:0];
        end else begin
            r = (q > Q_NEG_LIMIT) ? S32_MIN : (~q[31:0] + 32'd1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/efr_divider.sv
// pipelined three-lane divider: momentum over density, one beat per cycle
`default_nettype none

module efr_divider (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire efr_pkg::t_cell  i_cell,
    output logic                 o_valid,
    output efr_pkg::t_side       o_side,
    output efr_pkg::t_vel        o_vel
);

    localparam int NS = efr_pkg::DIV_STAGES;

    logic [NS:0]         r_valid;
    efr_pkg::t_side      r_side [0:NS];
    logic [2:0]          r_sign [0:NS];
    efr_pkg::t_div_lane  r_lane [0:NS][0:2];

    logic                r_q_valid;
    efr_pkg::t_side      r_q_side;
    efr_pkg::t_vel       r_q_vel;

    logic signed [31:0]  n_mom [0:2];
    logic [31:0]         n_mag [0:2];
    efr_pkg::t_side      n_side;

    always_comb begin
        n_mom[0] = i_cell.mom_x;
        n_mom[1] = i_cell.mom_y;
        n_mom[2] = i_cell.mom_z;
        for (int j = 0; j < 3; j++) begin
            n_mag[j] = n_mom[j][31] ? (~n_mom[j] + 32'd1) : n_mom[j];
        end
        n_side.rho  = i_cell.density;
        n_side.en   = i_cell.total_energy;
        n_side.nx   = i_cell.normal_x;
        n_side.ny   = i_cell.normal_y;
        n_side.nz   = i_cell.normal_z;
        n_side.rot  = i_cell.rotation_term;
        n_side.nmag = i_cell.normal_mag;
        n_side.neg  = i_cell.normal_negate;
        n_side.bad  = i_cell.density[31] || (i_cell.density == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_valid   <= {r_valid[NS-1:0], i_valid};
            r_q_valid <= r_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        r_sign[0] <= {n_mom[2][31], n_mom[1][31], n_mom[0][31]};
        for (int j = 0; j < 3; j++) begin
            r_lane[0][j] <= {31'd0, n_mag[j], 16'd0};
        end
        for (int k = 1; k <= NS; k++) begin
            r_side[k] <= r_side[k-1];
            r_sign[k] <= r_sign[k-1];
            for (int j = 0; j < 3; j++) begin
                r_lane[k][j] <= efr_pkg::div_steps(r_lane[k-1][j], r_side[k-1].rho[30:0]);
            end
        end
        r_q_side <= r_side[NS];
        r_q_vel  <= {efr_pkg::quo_sat(r_lane[NS][0].dq, r_sign[NS][0]),
                     efr_pkg::quo_sat(r_lane[NS][1].dq, r_sign[NS][1]),
                     efr_pkg::quo_sat(r_lane[NS][2].dq, r_sign[NS][2])};
    end

    assign o_valid = r_q_valid;
    assign o_side  = r_q_side;
    assign o_vel   = r_q_vel;

endmodule

`default_nettype wire

// File: hw/rtl/efr_flux.sv
// multiply chain from velocities to the five face fluxes
`default_nettype none

module efr_flux (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire efr_pkg::t_side  i_side,
    input  wire efr_pkg::t_vel   i_vel,
    input  wire logic [17:0]     i_gamma,
    output logic                 o_valid,
    output efr_pkg::t_flux       o_flux
);

    logic [efr_pkg::FLUX_STAGES-1:0] r_valid;

    // stage a: velocity products
    logic signed [63:0] r_a_pnx, r_a_pny, r_a_pnz, r_a_puu, r_a_pvv, r_a_pww, r_a_prot;
    logic signed [31:0] r_a_u, r_a_v, r_a_w, r_a_rho, r_a_en;
    logic [30:0]        r_a_nmag;
    logic               r_a_neg, r_a_bad;
    // stage b: normal velocity and speed squared
    logic signed [31:0] r_b_vn, r_b_vsq, r_b_u, r_b_v, r_b_w, r_b_rho, r_b_en;
    logic signed [45:0] r_b_rotq;
    logic [30:0]        r_b_nmag;
    logic               r_b_bad;
    // stage c: density products
    logic signed [63:0] r_c_pvs, r_c_pms;
    logic signed [45:0] r_c_rotq;
    logic signed [31:0] r_c_vn, r_c_u, r_c_v, r_c_w, r_c_en;
    logic [30:0]        r_c_nmag;
    logic               r_c_bad;
    // stage d: internal energy and mass flux
    logic signed [31:0] r_d_eint, r_d_mass, r_d_vn, r_d_u, r_d_v, r_d_w, r_d_en;
    logic [30:0]        r_d_nmag;
    logic               r_d_bad;
    // stage e: pressure and momentum products
    logic signed [50:0] r_e_pp;
    logic signed [63:0] r_e_pmu, r_e_pmv, r_e_pmw;
    logic signed [31:0] r_e_mass, r_e_vn, r_e_en;
    logic [30:0]        r_e_nmag;
    logic               r_e_bad;
    // stage f: pressure
    logic signed [31:0] r_f_p, r_f_mass, r_f_vn, r_f_en;
    logic signed [47:0] r_f_mu, r_f_mv, r_f_mw;
    logic [30:0]        r_f_nmag;
    logic               r_f_bad;
    // stage g: pressure force and enthalpy
    logic signed [63:0] r_g_ppn;
    logic signed [31:0] r_g_ep, r_g_mass, r_g_vn;
    logic signed [47:0] r_g_mu, r_g_mv, r_g_mw;
    logic               r_g_bad;
    // stage h: momentum fluxes, energy product
    logic signed [63:0] r_h_pe;
    logic signed [31:0] r_h_xm, r_h_ym, r_h_zm, r_h_mass;
    logic               r_h_bad;
    // output stage
    efr_pkg::t_flux     r_o_flux;

    logic signed [49:0] n_b_dot;
    logic signed [49:0] n_b_vsq;
    logic signed [18:0] n_gm1;

    always_comb begin
        n_b_dot = 50'(r_a_pnx >>> 16) + 50'(r_a_pny >>> 16) + 50'(r_a_pnz >>> 16);
        if (r_a_neg) begin
            n_b_dot = -n_b_dot;
        end
        n_b_vsq = 50'(r_a_puu >>> 16) + 50'(r_a_pvv >>> 16) + 50'(r_a_pww >>> 16);
        n_gm1   = $signed({1'b0, i_gamma}) - efr_pkg::Q_ONE_G;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[efr_pkg::FLUX_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_pnx  <= i_side.nx * i_vel.u;
        r_a_pny  <= i_side.ny * i_vel.v;
        r_a_pnz  <= i_side.nz * i_vel.w;
        r_a_puu  <= i_vel.u * i_vel.u;
        r_a_pvv  <= i_vel.v * i_vel.v;
        r_a_pww  <= i_vel.w * i_vel.w;
        r_a_prot <= i_side.rho * i_side.rot;
        r_a_u    <= i_vel.u;
        r_a_v    <= i_vel.v;
        r_a_w    <= i_vel.w;
        r_a_rho  <= i_side.rho;
        r_a_en   <= i_side.en;
        r_a_nmag <= i_side.nmag;
        r_a_neg  <= i_side.neg;
        r_a_bad  <= i_side.bad;

        r_b_vn   <= efr_pkg::sat32(64'(n_b_dot));
        r_b_vsq  <= efr_pkg::sat32(64'(n_b_vsq));
        r_b_rotq <= 46'(r_a_prot >>> 18);
        r_b_u    <= r_a_u;
        r_b_v    <= r_a_v;
        r_b_w    <= r_a_w;
        r_b_rho  <= r_a_rho;
        r_b_en   <= r_a_en;
        r_b_nmag <= r_a_nmag;
        r_b_bad  <= r_a_bad;

        r_c_pvs  <= r_b_rho * r_b_vsq;
        r_c_pms  <= r_b_rho * r_b_vn;
        r_c_rotq <= r_b_rotq;
        r_c_vn   <= r_b_vn;
        r_c_u    <= r_b_u;
        r_c_v    <= r_b_v;
        r_c_w    <= r_b_w;
        r_c_en   <= r_b_en;
        r_c_nmag <= r_b_nmag;
        r_c_bad  <= r_b_bad;

        r_d_eint <= efr_pkg::sat32(64'(r_c_en) - (r_c_pvs >>> 17) + 64'(r_c_rotq));
        r_d_mass <= efr_pkg::sat32(r_c_pms >>> 16);
        r_d_vn   <= r_c_vn;
        r_d_u    <= r_c_u;
        r_d_v    <= r_c_v;
        r_d_w    <= r_c_w;
        r_d_en   <= r_c_en;
        r_d_nmag <= r_c_nmag;
        r_d_bad  <= r_c_bad;

        r_e_pp   <= n_gm1 * r_d_eint;
        r_e_pmu  <= r_d_mass * r_d_u;
        r_e_pmv  <= r_d_mass * r_d_v;
        r_e_pmw  <= r_d_mass * r_d_w;
        r_e_mass <= r_d_mass;
        r_e_vn   <= r_d_vn;
        r_e_en   <= r_d_en;
        r_e_nmag <= r_d_nmag;
        r_e_bad  <= r_d_bad;

        r_f_p    <= efr_pkg::sat32(64'(r_e_pp >>> 16));
        r_f_mu   <= 48'(r_e_pmu >>> 16);
        r_f_mv   <= 48'(r_e_pmv >>> 16);
        r_f_mw   <= 48'(r_e_pmw >>> 16);
        r_f_mass <= r_e_mass;
        r_f_vn   <= r_e_vn;
        r_f_en   <= r_e_en;
        r_f_nmag <= r_e_nmag;
        r_f_bad  <= r_e_bad;

        r_g_ppn  <= $signed({1'b0, r_f_nmag}) * r_f_p;
        r_g_ep   <= efr_pkg::sat32(64'(r_f_en) + 64'(r_f_p));
        r_g_mu   <= r_f_mu;
        r_g_mv   <= r_f_mv;
        r_g_mw   <= r_f_mw;
        r_g_mass <= r_f_mass;
        r_g_vn   <= r_f_vn;
        r_g_bad  <= r_f_bad;

        // pressure force is added unsaturated, clamp only the sum
        r_h_pe   <= r_g_ep * r_g_vn;
        r_h_xm   <= efr_pkg::sat32(64'(r_g_mu) + (r_g_ppn >>> 16));
        r_h_ym   <= efr_pkg::sat32(64'(r_g_mv) + (r_g_ppn >>> 16));
        r_h_zm   <= efr_pkg::sat32(64'(r_g_mw) + (r_g_ppn >>> 16));
        r_h_mass <= r_g_mass;
        r_h_bad  <= r_g_bad;

        if (r_h_bad) begin
            r_o_flux <= {160'd0, 1'b1};
        end else begin
            r_o_flux <= {r_h_mass, r_h_xm, r_h_ym, r_h_zm,
                         efr_pkg::sat32(r_h_pe >>> 16), 1'b0};
        end
    end

    assign o_valid = r_valid[efr_pkg::FLUX_STAGES-1];
    assign o_flux  = r_o_flux;

endmodule

`default_nettype wire

// File: hw/rtl/euler_face_flux_rotating.sv
// top level: inviscid euler face flux in a rotating frame, q16.16 pipeline
`default_nettype none

`include "assert_macros.svh"

// Takes one cell/face beat per clock cycle whenever start is high; busy is low
// at all times outside reset. Each result appears with o_done high, held for
// exactly one cycle, and must be captured then: the block has no way to hold a
// result. The pipeline is the entry register, 12 divider stages that each
// retire 4 of the 48 quotient bits of the three momentum/density divisions, a
// velocity saturation register, and a nine-stage chain of 32-bit multiplies.
// Throughput is one beat per cycle. gamma_ratio is taken on the configuration
// channel (always ready) and should be changed only while no beat is in flight.
module euler_face_flux_rotating (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_density,
    input  wire logic signed [31:0] i_mom_x,
    input  wire logic signed [31:0] i_mom_y,
    input  wire logic signed [31:0] i_mom_z,
    input  wire logic signed [31:0] i_total_energy,
    input  wire logic signed [31:0] i_normal_x,
    input  wire logic signed [31:0] i_normal_y,
    input  wire logic signed [31:0] i_normal_z,
    input  wire logic               i_normal_negate,
    input  wire logic [30:0]        i_normal_mag,
    input  wire logic signed [31:0] i_rotation_term,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [17:0]        i_cfg_data,
    output logic                    o_done,
    output logic signed [31:0]      o_mass_flux,
    output logic signed [31:0]      o_xmom_flux,
    output logic signed [31:0]      o_ymom_flux,
    output logic signed [31:0]      o_zmom_flux,
    output logic signed [31:0]      o_energy_flux,
    output logic                    o_bad_density
);

    logic [17:0]     r_gamma;
    logic            n_accept;
    efr_pkg::t_cell  n_cell;
    logic            w_div_valid;
    efr_pkg::t_side  w_div_side;
    efr_pkg::t_vel   w_div_vel;
    logic            w_flux_valid;
    efr_pkg::t_flux  w_flux;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= efr_pkg::GAMMA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gamma <= i_cfg_data;
        end
    end

    always_comb begin
        n_cell.density       = i_density;
        n_cell.mom_x         = i_mom_x;
        n_cell.mom_y         = i_mom_y;
        n_cell.mom_z         = i_mom_z;
        n_cell.total_energy  = i_total_energy;
        n_cell.normal_x      = i_normal_x;
        n_cell.normal_y      = i_normal_y;
        n_cell.normal_z      = i_normal_z;
        n_cell.normal_negate = i_normal_negate;
        n_cell.normal_mag    = i_normal_mag;
        n_cell.rotation_term = i_rotation_term;
    end

    efr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_accept),
        .i_cell  (n_cell),
        .o_valid (w_div_valid),
        .o_side  (w_div_side),
        .o_vel   (w_div_vel)
    );

    efr_flux u_flux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .i_side  (w_div_side),
        .i_vel   (w_div_vel),
        .i_gamma (r_gamma),
        .o_valid (w_flux_valid),
        .o_flux  (w_flux)
    );

    assign o_done        = w_flux_valid;
    assign o_mass_flux   = w_flux.mass;
    assign o_xmom_flux   = w_flux.xmom;
    assign o_ymom_flux   = w_flux.ymom;
    assign o_zmom_flux   = w_flux.zmom;
    assign o_energy_flux = w_flux.energy;
    assign o_bad_density = w_flux.bad;

    `ASSERT_IMPLIES(a_done_has_beat, i_clk, i_rst_n, o_done, $past(start && !busy, efr_pkg::LATENCY), "result strobe without a matching input beat")
    `ASSERT_IMPLIES(a_bad_tracks_density, i_clk, i_rst_n, o_done, o_bad_density == ($past(i_density, efr_pkg::LATENCY) <= 32'sd0), "density flag does not match its input beat")
    `ASSERT_NEVER(a_bad_gives_zero, i_clk, i_rst_n, o_done && o_bad_density && (o_mass_flux != 32'sd0 || o_xmom_flux != 32'sd0 || o_ymom_flux != 32'sd0 || o_zmom_flux != 32'sd0 || o_energy_flux != 32'sd0), "nonzero flux on a bad density result")

endmodule

`default_nettype wire
